[hw/rtl/c2e_pkg.sv]
`default_nettype none

package c2e_pkg;

	// widths of the packed stream words
	localparam int unsigned IN_BITS   = 41;
	localparam int unsigned IN_TDATA  = 48;
	localparam int unsigned OUT_BITS  = 84;
	localparam int unsigned OUT_TDATA = 88;
	localparam int unsigned SECS_W    = 36;
	localparam int unsigned TOTAL_W   = 18;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROLL,
		ST_DAYS,
		ST_MAC_H,
		ST_MAC_M,
		ST_MAC_S
	} ctl_state_t;

	typedef enum logic [1:0] {
		MAC_HOUR,
		MAC_MIN,
		MAC_SEC
	} mac_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     roll;
		logic     days;
		logic     mac;
		mac_sel_t mac_sel;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic roll_need;
		logic out_free;
	} dp_status_t;

	// floor(v / 60) for v in -131..129
	function automatic logic signed [2:0] fdiv60(input logic signed [8:0] v);
		logic signed [2:0] q;
		begin
			if (v >= 9'sd120)       q = 3'sd2;
			else if (v >= 9'sd60)   q = 3'sd1;
			else if (v >= 9'sd0)    q = 3'sd0;
			else if (v >= -9'sd60)  q = -3'sd1;
			else if (v >= -9'sd120) q = -3'sd2;
			else                    q = -3'sd3;
			return q;
		end
	endfunction

	// floor(v / 24) for v in -67..65
	function automatic logic signed [2:0] fdiv24(input logic signed [7:0] v);
		logic signed [2:0] q;
		begin
			if (v >= 8'sd48)       q = 3'sd2;
			else if (v >= 8'sd24)  q = 3'sd1;
			else if (v >= 8'sd0)   q = 3'sd0;
			else if (v >= -8'sd24) q = -3'sd1;
			else if (v >= -8'sd48) q = -3'sd2;
			else                   q = -3'sd3;
			return q;
		end
	endfunction

	// month length, February grows in a leap year
	function automatic logic [4:0] days_in(input logic [3:0] mon, input logic leap);
		logic [4:0] d;
		begin
			unique case (mon)
				4'd1:                     d = leap ? 5'd29 : 5'd28;
				4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
				default:                  d = 5'd31;
			endcase
			return d;
		end
	endfunction

	// days before the first of a month in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] mon);
		logic [8:0] d;
		begin
			unique case (mon)
				4'd0:    d = 9'd0;
				4'd1:    d = 9'd31;
				4'd2:    d = 9'd59;
				4'd3:    d = 9'd90;
				4'd4:    d = 9'd120;
				4'd5:    d = 9'd151;
				4'd6:    d = 9'd181;
				4'd7:    d = 9'd212;
				4'd8:    d = 9'd243;
				4'd9:    d = 9'd273;
				4'd10:   d = 9'd304;
				default: d = 9'd334;
			endcase
			return d;
		end
	endfunction

	// (u + 4) mod 7; 8 is 1 mod 7, so octal digits are summed twice
	function automatic logic [2:0] mod7_plus4(input logic [10:0] u);
		logic [4:0] s1;
		logic [3:0] s2;
		logic [2:0] r;
		logic [3:0] w;
		begin
			s1 = 5'(u[2:0]) + 5'(u[5:3]) + 5'(u[8:6]) + 5'(u[10:9]);
			s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
			r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
			w  = 4'(r) + 4'd4;
			return (w >= 4'd7) ? 3'(w - 4'd7) : w[2:0];
		end
	endfunction

endpackage

`default_nettype wire

[hw/rtl/calendar_to_epoch_seconds_core.sv]
// Broken-down time to seconds since 1970-01-01 00:00 (no zone, no DST).
// Input stream s_axis: one request per beat carries second, minute, hour,
// day of month, month and year since 1900. Output stream m_axis: one
// result per request with epoch seconds, the normalized fields, the day
// of year and the weekday.
// Sequence: carries are taken in the accept cycle; the controller then
// walks one state per step: a month-length check that also rolls the day
// into the next month (repeated for each rollover, up to two), the day
// count, then three passes of the shared multiply-add (x24, x60, x60), the
// last one loading the result. The next request is taken the cycle after
// the result is loaded, so no new request is taken while one is in work.
// The result sits in an output register; the next request is accepted and
// processed while it waits. If the receiver stalls and the register still
// holds an untaken result, the controller waits in its final step and
// s_axis_tready stays low until the result moves.
// Reset (arst_n low) empties the output register and returns to idle.
`default_nettype none

module calendar_to_epoch_seconds_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// second_in[7:0], minute_in[15:8], hour_in[22:16], day_in[28:23],
	// month_in[32:29], year_in[40:33], zero fill
	input  wire logic [c2e_pkg::IN_TDATA-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// epoch_seconds[35:0], second_out[41:36], minute_out[47:42],
	// hour_out[52:48], day_out[58:53], month_out[62:59], year_out[70:63],
	// day_of_year[80:71], weekday[83:81], zero fill
	output logic [c2e_pkg::OUT_TDATA-1:0]      m_axis_tdata
);

	c2e_pkg::dp_cmd_t    cmd;
	c2e_pkg::dp_status_t status;

	// sequencer: one state per step of the conversion
	c2e_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	// carries, month rollover, day count, multiply-add and result register
	c2e_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.status        (status)
	);

`ifndef SYNTH
	// one request at a time: busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while busy");

	// time-of-day fields leave normalized
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[41:36] < 6'd60) && (m_axis_tdata[47:42] < 6'd60)
			&& (m_axis_tdata[52:48] < 5'd24)))
		else $error("time of day out of range");

	// month and weekday in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[62:59] < 4'd12) && (m_axis_tdata[83:81] != 3'd7)))
		else $error("month or weekday out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/c2e_ctrl.sv]
`default_nettype none

module c2e_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire c2e_pkg::dp_status_t status,
	output c2e_pkg::dp_cmd_t       cmd
);

	c2e_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2e_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			c2e_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = c2e_pkg::ST_ROLL;
			end
			c2e_pkg::ST_ROLL: begin
				if (!status.roll_need) state_d = c2e_pkg::ST_DAYS;
			end
			c2e_pkg::ST_DAYS:  state_d = c2e_pkg::ST_MAC_H;
			c2e_pkg::ST_MAC_H: state_d = c2e_pkg::ST_MAC_M;
			c2e_pkg::ST_MAC_M: state_d = c2e_pkg::ST_MAC_S;
			c2e_pkg::ST_MAC_S: begin
				if (status.out_free) state_d = c2e_pkg::ST_IDLE;
			end
			default: state_d = c2e_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		cmd.mac_sel   = c2e_pkg::MAC_HOUR;
		unique case (state_q)
			c2e_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load_in   = s_axis_tvalid;
			end
			c2e_pkg::ST_ROLL: cmd.roll = status.roll_need;
			c2e_pkg::ST_DAYS: cmd.days = 1'b1;
			c2e_pkg::ST_MAC_H: begin
				cmd.mac     = 1'b1;
				cmd.mac_sel = c2e_pkg::MAC_HOUR;
			end
			c2e_pkg::ST_MAC_M: begin
				cmd.mac     = 1'b1;
				cmd.mac_sel = c2e_pkg::MAC_MIN;
			end
			c2e_pkg::ST_MAC_S: begin
				cmd.mac_sel  = c2e_pkg::MAC_SEC;
				cmd.load_out = status.out_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/c2e_datapath.sv]
`default_nettype none

module c2e_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [c2e_pkg::IN_TDATA-1:0]       s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [c2e_pkg::OUT_TDATA-1:0]           m_axis_tdata,
	input  wire c2e_pkg::dp_cmd_t                   cmd,
	output c2e_pkg::dp_status_t                     status
);

	// input carries
	logic signed [7:0] sec_i, min_i;
	logic signed [6:0] hour_i;
	logic        [5:0] day_i;
	logic        [3:0] month_i;
	logic        [7:0] year_i;
	logic signed [2:0] q_s, q_m, q_h;
	logic signed [8:0] sec9, min9, sec_r, min_r;
	logic signed [7:0] hour8, hour_r, mday_n;

	// working registers
	logic        [5:0] sec_q, min_q;
	logic        [4:0] hour_q;
	logic signed [7:0] mday_q;
	logic        [3:0] mon_q;
	logic        [8:0] year_q;
	logic signed [9:0] yday_q;
	logic signed [10:0] wsum_q;
	logic        [2:0] wday_q;
	logic signed [c2e_pkg::SECS_W-1:0] acc_q;

	logic                   leap;
	logic [4:0]             dim;
	logic signed [9:0]      yday_n, yoff, fl;
	logic signed [c2e_pkg::TOTAL_W-1:0] total;
	logic [5:0]             mac_k, mac_add;
	logic signed [c2e_pkg::SECS_W-1:0] mac_res;

	logic                              out_valid_q;
	logic [c2e_pkg::OUT_BITS-1:0]      out_q;

	assign sec_i   = s_axis_tdata[7:0];
	assign min_i   = s_axis_tdata[15:8];
	assign hour_i  = s_axis_tdata[22:16];
	assign day_i   = s_axis_tdata[28:23];
	assign month_i = s_axis_tdata[32:29];
	assign year_i  = s_axis_tdata[40:33];

	always_comb begin
		sec9   = {sec_i[7], sec_i};
		q_s    = c2e_pkg::fdiv60(sec9);
		sec_r  = sec9 - 9'({{6{q_s[2]}}, q_s} * 9'sd60);
		min9   = {min_i[7], min_i} + {{6{q_s[2]}}, q_s};
		q_m    = c2e_pkg::fdiv60(min9);
		min_r  = min9 - 9'({{6{q_m[2]}}, q_m} * 9'sd60);
		hour8  = {hour_i[6], hour_i} + {{5{q_m[2]}}, q_m};
		q_h    = c2e_pkg::fdiv24(hour8);
		hour_r = hour8 - 8'({{5{q_h[2]}}, q_h} * 8'sd24);
		mday_n = $signed({2'b00, day_i}) + {{5{q_h[2]}}, q_h};
	end

	// month length test for the day rollover
	assign leap = (year_q[1:0] == 2'b00);
	assign dim  = c2e_pkg::days_in(mon_q, leap);
	assign status.roll_need = (mday_q > $signed({3'b000, dim}));
	assign status.out_free  = !out_valid_q || m_axis_tready;

	// day counts
	always_comb begin
		yday_n = {{2{mday_q[7]}}, mday_q} - 10'sd1 + $signed({1'b0, c2e_pkg::cum_days(mon_q)})
			+ $signed({9'd0, (leap && (mon_q >= 4'd2))});
		yoff   = $signed({1'b0, year_q}) - 10'sd70;
		fl     = ($signed({1'b0, year_q}) - 10'sd69) >>> 2;
		total  = 18'($signed({{8{yoff[9]}}, yoff}) * 18'sd365)
			+ $signed({{8{fl[9]}}, fl}) + $signed({{8{yday_n[9]}}, yday_n});
	end

	// shared multiply-add: acc * k + field
	always_comb begin
		unique case (cmd.mac_sel)
			c2e_pkg::MAC_HOUR: begin
				mac_k   = 6'd24;
				mac_add = {1'b0, hour_q};
			end
			c2e_pkg::MAC_MIN: begin
				mac_k   = 6'd60;
				mac_add = min_q;
			end
			default: begin
				mac_k   = 6'd60;
				mac_add = sec_q;
			end
		endcase
		mac_res = c2e_pkg::SECS_W'(acc_q * $signed({1'b0, mac_k}))
			+ $signed({30'd0, mac_add});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sec_q  <= sec_r[5:0];
			min_q  <= min_r[5:0];
			hour_q <= hour_r[4:0];
			mday_q <= mday_n;
			if (month_i >= 4'd12) begin
				mon_q  <= month_i - 4'd12;
				year_q <= {1'b0, year_i} + 9'd1;
			end else begin
				mon_q  <= month_i;
				year_q <= {1'b0, year_i};
			end
		end else if (cmd.roll) begin
			mday_q <= mday_q - $signed({3'b000, dim});
			if (mon_q == 4'd11) begin
				mon_q  <= 4'd0;
				year_q <= year_q + 9'd1;
			end else begin
				mon_q  <= mon_q + 4'd1;
			end
		end
		if (cmd.days) begin
			yday_q <= yday_n;
			wsum_q <= {yoff[9], yoff} + {fl[9], fl} + {yday_n[9], yday_n};
			acc_q  <= {{(c2e_pkg::SECS_W - c2e_pkg::TOTAL_W){total[c2e_pkg::TOTAL_W-1]}},
				total};
		end else if (cmd.mac) begin
			acc_q <= mac_res;
		end
		if (cmd.mac && (cmd.mac_sel == c2e_pkg::MAC_HOUR)) begin
			wday_q <= c2e_pkg::mod7_plus4(11'(wsum_q) + 11'd700);
		end
		if (cmd.load_out) begin
			out_q <= {wday_q, yday_q, year_q[7:0], mon_q, mday_q[5:0], hour_q,
				min_q, sec_q, mac_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(c2e_pkg::OUT_TDATA - c2e_pkg::OUT_BITS){1'b0}}, out_q};

endmodule

`default_nettype wire
